@@ design/ssp_pkg.sv @@
// Shared types, constants and a helper function of the S-curve step pulse profiler.
package ssp_pkg;

   localparam int MAX_DISTANCE_DEFAULT = 16384;

   localparam logic [31:0] NS_PER_SECOND = 32'd1000000000;
   localparam logic [31:0] SPEED_FLOOR   = 32'd131072;
   localparam logic [48:0] INTERVAL_INIT = 49'h0_8000_0000;

   localparam logic [31:0] MAX_SPEED_RESET  = 32'd69905067;
   localparam logic [31:0] MAX_ACCEL_RESET  = 32'd11650844;
   localparam logic [31:0] JERK_RESET       = 32'd466034;
   localparam logic [23:0] MIN_POS_RESET    = 24'd0;
   localparam logic [23:0] MAX_POS_RESET    = 24'd9600;
   localparam logic [6:0]  OVERRIDE_RESET   = 7'd100;

   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [2:0] CSR_MAX_SPEED = 3'd0;
   localparam logic [2:0] CSR_MAX_ACCEL = 3'd1;
   localparam logic [2:0] CSR_JERK      = 3'd2;
   localparam logic [2:0] CSR_MIN_POS   = 3'd3;
   localparam logic [2:0] CSR_MAX_POS   = 3'd4;
   localparam logic [2:0] CSR_OVERRIDE  = 3'd5;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_REJECTED = 3'd1,
      STATUS_FAULT    = 3'd2,
      STATUS_IDLE     = 3'd3,
      STATUS_FINISHED = 3'd4
   } status_type;

   typedef struct packed {
      logic [31:0] max_speed;
      logic [31:0] max_accel;
      logic [31:0] jerk_limit;
   } motion_cfg_type;

   // Integer factor 100 / override, with an override of zero taken as one.
   function automatic logic [6:0] override_factor(input logic [6:0] pct);
      logic [6:0] f;
      f = 7'd0;
      priority if (pct == 7'd0 || pct == 7'd1) f = 7'd100;
      else if (pct == 7'd2)   f = 7'd50;
      else if (pct == 7'd3)   f = 7'd33;
      else if (pct == 7'd4)   f = 7'd25;
      else if (pct == 7'd5)   f = 7'd20;
      else if (pct == 7'd6)   f = 7'd16;
      else if (pct == 7'd7)   f = 7'd14;
      else if (pct == 7'd8)   f = 7'd12;
      else if (pct == 7'd9)   f = 7'd11;
      else if (pct == 7'd10)  f = 7'd10;
      else if (pct == 7'd11)  f = 7'd9;
      else if (pct == 7'd12)  f = 7'd8;
      else if (pct <= 7'd14)  f = 7'd7;
      else if (pct <= 7'd16)  f = 7'd6;
      else if (pct <= 7'd20)  f = 7'd5;
      else if (pct <= 7'd25)  f = 7'd4;
      else if (pct <= 7'd33)  f = 7'd3;
      else if (pct <= 7'd50)  f = 7'd2;
      else if (pct <= 7'd100) f = 7'd1;
      else f = 7'd0;
      return f;
   endfunction

endpackage

@@ design/ssp_if.sv @@
// Channel interfaces: move and tick requests, results and register writes.
interface ssp_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [23:0] target_position;
   logic               fault;
   modport source (output valid, op, target_position, fault, input ready);
   modport sink (input valid, op, target_position, fault, output ready);
endinterface

interface ssp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [35:0]        interval_ns;
   logic signed [23:0] position;
   logic               direction;
   logic               pulse_level;
   logic               enable;
   modport source (output valid, status, interval_ns, position, direction, pulse_level,
                   enable, input ready);
   modport sink (input valid, status, interval_ns, position, direction, pulse_level,
                 enable, output ready);
endinterface

interface ssp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/ssp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ssp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/ssp_profile.sv @@
// Profile builder: iterates speed, acceleration and interval over the first half of a move.
module ssp_profile #(
   parameter int MAX_DISTANCE = ssp_pkg::MAX_DISTANCE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [$clog2(MAX_DISTANCE+1)-1:0] move_span,
   input  ssp_pkg::motion_cfg_type       cfg,
   output logic                          busy,
   output logic                          wr_en,
   output logic [$clog2(((MAX_DISTANCE+1)/2) > 1 ? ((MAX_DISTANCE+1)/2) : 2)-1:0] wr_addr,
   output logic [31:0]                   wr_data
);
   import ssp_pkg::*;

   localparam int DIST_W     = $clog2(MAX_DISTANCE + 1);
   localparam int HALF_DEPTH = (MAX_DISTANCE + 1) / 2;
   localparam int ADDR_W     = $clog2(HALF_DEPTH > 1 ? HALF_DEPTH : 2);

   typedef enum logic [3:0] {
      B_IDLE, B_STEP, B_JH, B_JL, B_JSUM, B_ACC, B_AH, B_AL, B_ASUM, B_VEL,
      B_DIV, B_NSH, B_NSL, B_NSUM
   } build_state_type;

   build_state_type state_ff;
   logic [DIST_W-1:0] p_ff, half_ff, quarter_ff;
   logic [31:0] v_ff, a_ff, den_ff, rem_ff;
   logic [48:0] t_ff;
   logic [49:0] d_ff;
   logic [63:0] prod_ff, acc_ff;
   logic [5:0]  cnt_ff;
   logic        wr_en_ff;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic [31:0] wr_data_ff;

   logic [31:0] mul_x, mul_y;
   logic [DIST_W:0] half_in;
   logic [50:0] asum, vsum;
   logic [32:0] rem_shift;
   logic        q_bit;
   logic [63:0] ns_sum;
   logic [49:0] d_in;

   always_comb begin
      mul_x = 32'd0;
      mul_y = 32'd0;
      unique case (state_ff)
         B_JH: begin
            mul_x = cfg.jerk_limit;
            mul_y = {15'd0, t_ff[48:32]};
         end
         B_JL: begin
            mul_x = cfg.jerk_limit;
            mul_y = t_ff[31:0];
         end
         B_AH: begin
            mul_x = a_ff;
            mul_y = {15'd0, t_ff[48:32]};
         end
         B_AL: begin
            mul_x = a_ff;
            mul_y = t_ff[31:0];
         end
         B_NSH: begin
            mul_x = NS_PER_SECOND;
            mul_y = {15'd0, t_ff[48:32]};
         end
         B_NSL: begin
            mul_x = NS_PER_SECOND;
            mul_y = t_ff[31:0];
         end
         default: begin
            mul_x = 32'd0;
            mul_y = 32'd0;
         end
      endcase
   end

   assign half_in   = ({1'b0, move_span} + {{DIST_W{1'b0}}, 1'b1}) >> 1;
   assign asum      = {19'd0, a_ff} + {1'b0, d_ff};
   assign vsum      = {19'd0, v_ff} + {1'b0, d_ff};
   assign rem_shift = {rem_ff, (cnt_ff == 6'd48)};
   assign q_bit     = (rem_shift >= {1'b0, den_ff});
   assign ns_sum    = acc_ff + {32'd0, prod_ff[63:32]};
   assign d_in      = acc_ff[49:0] + {18'd0, prod_ff[63:32]};

   always_ff @(posedge clock) begin
      prod_ff  <= mul_x * mul_y;
      if (reset) begin
         state_ff <= B_IDLE;
         wr_en_ff <= 1'b0;
      end else begin
         wr_en_ff <= (state_ff == B_NSUM);
         unique case (state_ff)
            B_IDLE: begin
               if (start) begin
                  p_ff       <= '0;
                  half_ff    <= half_in[DIST_W-1:0];
                  quarter_ff <= move_span >> 2;
                  v_ff       <= SPEED_FLOOR;
                  a_ff       <= 32'd0;
                  t_ff       <= INTERVAL_INIT;
                  state_ff   <= B_STEP;
               end
            end
            B_STEP: begin
               if (p_ff == half_ff) begin
                  state_ff <= B_IDLE;
               end else if (v_ff < cfg.max_speed) begin
                  state_ff <= B_JH;
               end else begin
                  // At cruise speed the interval is the reciprocal of the cap.
                  v_ff     <= cfg.max_speed;
                  a_ff     <= 32'd0;
                  den_ff   <= (cfg.max_speed == 32'd0) ? 32'd1 : cfg.max_speed;
                  rem_ff   <= 32'd0;
                  cnt_ff   <= 6'd48;
                  state_ff <= B_DIV;
               end
            end
            B_JH: state_ff <= B_JL;
            B_JL: begin
               acc_ff   <= prod_ff;
               state_ff <= B_JSUM;
            end
            B_JSUM: begin
               d_ff     <= d_in;
               state_ff <= B_ACC;
            end
            B_ACC: begin
               if (p_ff < quarter_ff) begin
                  a_ff <= (asum > {19'd0, cfg.max_accel}) ? cfg.max_accel : asum[31:0];
               end else begin
                  a_ff <= ({18'd0, a_ff} > d_ff) ? (a_ff - d_ff[31:0]) : 32'd0;
               end
               state_ff <= B_AH;
            end
            B_AH: state_ff <= B_AL;
            B_AL: begin
               acc_ff   <= prod_ff;
               state_ff <= B_ASUM;
            end
            B_ASUM: begin
               d_ff     <= d_in;
               state_ff <= B_VEL;
            end
            B_VEL: begin
               if (vsum > {19'd0, cfg.max_speed}) begin
                  v_ff   <= cfg.max_speed;
                  a_ff   <= 32'd0;
                  den_ff <= (cfg.max_speed == 32'd0) ? 32'd1 : cfg.max_speed;
               end else if (p_ff >= quarter_ff && vsum < {19'd0, SPEED_FLOOR}) begin
                  v_ff   <= SPEED_FLOOR;
                  a_ff   <= 32'd0;
                  den_ff <= SPEED_FLOOR;
               end else begin
                  v_ff   <= vsum[31:0];
                  den_ff <= (vsum[31:0] == 32'd0) ? 32'd1 : vsum[31:0];
               end
               rem_ff   <= 32'd0;
               cnt_ff   <= 6'd48;
               state_ff <= B_DIV;
            end
            B_DIV: begin
               // Restoring division of 2^48 by the speed, one quotient bit per cycle.
               rem_ff <= q_bit ? (rem_shift[31:0] - den_ff) : rem_shift[31:0];
               t_ff   <= {t_ff[47:0], q_bit};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd0) begin
                  state_ff <= B_NSH;
               end
            end
            B_NSH: state_ff <= B_NSL;
            B_NSL: begin
               acc_ff   <= prod_ff;
               state_ff <= B_NSUM;
            end
            B_NSUM: begin
               wr_addr_ff <= p_ff[ADDR_W-1:0];
               wr_data_ff <= (ns_sum[63:32] != 32'd0) ? 32'hFFFF_FFFF : ns_sum[31:0];
               p_ff       <= p_ff + {{(DIST_W-1){1'b0}}, 1'b1};
               state_ff   <= B_STEP;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign busy    = (state_ff != B_IDLE);
   assign wr_en   = wr_en_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = wr_data_ff;
endmodule

@@ design/stepper_scurve_pulse_profiler.sv @@
// Top level: move commands build a mirrored interval profile in memory; ticks step through it.
// A rejected command, fault hold, idle or finishing tick goes from decode straight to its result;
// a step first passes the memory read and scale states. An accepted move builds its profile,
// one entry per step over half the distance, each by a bit-serial reciprocal, before its result
// is valid. One transaction at a time; the next is taken in the cycle after the result.
// Reset clears position, move state and registers; the profile memory is not cleared.
module stepper_scurve_pulse_profiler #(
   parameter int MAX_DISTANCE = ssp_pkg::MAX_DISTANCE_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   ssp_req_if.sink   req_ch,
   ssp_rsp_if.source rsp_ch,
   ssp_csr_if.sink   csr_ch
);
   import ssp_pkg::*;

   localparam int DIST_W     = $clog2(MAX_DISTANCE + 1);
   localparam int HALF_DEPTH = (MAX_DISTANCE + 1) / 2;
   localparam int ADDR_W     = $clog2(HALF_DEPTH > 1 ? HALF_DEPTH : 2);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_BUILD, ST_READ, ST_SCALE, ST_OUT
   } top_state_type;

   top_state_type state_ff;

   motion_cfg_type cfg_ff;
   logic signed [23:0] min_pos_ff, max_pos_ff;
   logic [6:0] override_ff;

   logic               op_ff, fault_ff;
   logic signed [23:0] target_ff;

   logic signed [23:0] current_pos_ff;
   logic               moving_ff, move_dir_ff, step_level_ff;
   logic [DIST_W-1:0]  step_index_ff, move_length_ff, half_ff;

   status_type  status_ff;
   logic [35:0] interval_ff;
   logic [38:0] scaled_ff;

   logic signed [24:0] diff;
   logic [24:0]        dist_abs;
   logic               move_ok;
   logic [DIST_W:0]    half_in;
   logic [DIST_W-1:0]  rd_index;
   logic               build_start, build_busy;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [31:0]        wr_data, rd_data;

   assign diff     = {target_ff[23], target_ff} - {current_pos_ff[23], current_pos_ff};
   assign dist_abs = diff[24] ? $unsigned(-diff) : $unsigned(diff);
   assign move_ok  = !moving_ff && (diff != 25'sd0) && (target_ff >= min_pos_ff) &&
                     (target_ff <= max_pos_ff) && (32'(dist_abs) <= 32'(MAX_DISTANCE));
   assign half_in  = ({1'b0, dist_abs[DIST_W-1:0]} + {{DIST_W{1'b0}}, 1'b1}) >> 1;
   assign build_start = (state_ff == ST_DECODE) && (op_ff == OP_MOVE) && move_ok;

   // The second half of a move reads the stored first half mirrored.
   assign rd_index = (step_index_ff < half_ff) ? step_index_ff
                   : (move_length_ff - {{(DIST_W-1){1'b0}}, 1'b1} - step_index_ff);

   ssp_profile #(.MAX_DISTANCE(MAX_DISTANCE)) u_profile (
      .clock     (clock),
      .reset     (reset),
      .start     (build_start),
      .move_span (dist_abs[DIST_W-1:0]),
      .cfg       (cfg_ff),
      .busy      (build_busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   ssp_ram #(.WIDTH(32), .DEPTH(HALF_DEPTH)) u_profile_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_index[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed  <= MAX_SPEED_RESET;
         cfg_ff.max_accel  <= MAX_ACCEL_RESET;
         cfg_ff.jerk_limit <= JERK_RESET;
         min_pos_ff        <= MIN_POS_RESET;
         max_pos_ff        <= MAX_POS_RESET;
         override_ff       <= OVERRIDE_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_MAX_SPEED: cfg_ff.max_speed  <= csr_ch.data;
            CSR_MAX_ACCEL: cfg_ff.max_accel  <= csr_ch.data;
            CSR_JERK:      cfg_ff.jerk_limit <= csr_ch.data;
            CSR_MIN_POS:   min_pos_ff        <= csr_ch.data[23:0];
            CSR_MAX_POS:   max_pos_ff        <= csr_ch.data[23:0];
            CSR_OVERRIDE:  override_ff       <= csr_ch.data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         current_pos_ff <= 24'sd0;
         moving_ff      <= 1'b0;
         move_dir_ff    <= 1'b0;
         step_level_ff  <= 1'b0;
         step_index_ff  <= '0;
         move_length_ff <= '0;
         half_ff        <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  op_ff     <= req_ch.op;
                  target_ff <= req_ch.target_position;
                  fault_ff  <= req_ch.fault;
                  state_ff  <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               interval_ff <= 36'd0;
               if (op_ff == OP_MOVE) begin
                  if (move_ok) begin
                     move_length_ff <= dist_abs[DIST_W-1:0];
                     half_ff        <= half_in[DIST_W-1:0];
                     step_index_ff  <= '0;
                     move_dir_ff    <= !diff[24];
                     moving_ff      <= 1'b1;
                     status_ff      <= STATUS_OK;
                     state_ff       <= ST_BUILD;
                  end else begin
                     status_ff <= STATUS_REJECTED;
                     state_ff  <= ST_OUT;
                  end
               end else if (fault_ff) begin
                  status_ff <= STATUS_FAULT;
                  state_ff  <= ST_OUT;
               end else if (moving_ff && step_index_ff < move_length_ff) begin
                  // The memory read of this entry is issued at this edge.
                  step_index_ff  <= step_index_ff + {{(DIST_W-1){1'b0}}, 1'b1};
                  step_level_ff  <= !step_level_ff;
                  current_pos_ff <= move_dir_ff ? current_pos_ff + 24'sd1
                                                : current_pos_ff - 24'sd1;
                  status_ff      <= STATUS_OK;
                  state_ff       <= ST_READ;
               end else if (moving_ff) begin
                  moving_ff <= 1'b0;
                  status_ff <= STATUS_FINISHED;
                  state_ff  <= ST_OUT;
               end else begin
                  status_ff <= STATUS_IDLE;
                  state_ff  <= ST_OUT;
               end
            end
            ST_BUILD: begin
               if (!build_busy) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_READ: begin
               scaled_ff <= rd_data * override_factor(override_ff);
               state_ff  <= ST_SCALE;
            end
            ST_SCALE: begin
               interval_ff <= (scaled_ff[38:36] != 3'd0) ? {36{1'b1}} : scaled_ff[35:0];
               state_ff    <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ch.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_OUT);
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.interval_ns = interval_ff;
   assign rsp_ch.position    = current_pos_ff;
   assign rsp_ch.direction   = move_dir_ff;
   assign rsp_ch.pulse_level = step_level_ff;
   assign rsp_ch.enable      = moving_ff;
endmodule

@@ test/stepper_scurve_pulse_profiler_test.sv @@
// Self-checking testbench of the S-curve step pulse profiler, with a scoreboard class.
module stepper_scurve_pulse_profiler_test;
   import ssp_pkg::*;

   typedef struct {
      logic [2:0]  status;
      logic [35:0] interval_ns;
      logic [23:0] position;
      logic        direction;
      logic        pulse_level;
      logic        enable;
   } pulse_result_type;

   class pulse_scoreboard;
      logic [31:0] max_speed, max_accel, jerk_limit;
      logic signed [23:0] min_pos, max_pos;
      logic [6:0] override_pct;
      logic signed [23:0] cur_pos;
      logic moving, move_dir, step_level;
      int step_index, move_length;
      logic [31:0] half_intervals [8192];
      pulse_result_type expected_results [$];
      int mismatches, checked, moves_accepted, moves_finished;

      function new();
         max_speed = MAX_SPEED_RESET;
         max_accel = MAX_ACCEL_RESET;
         jerk_limit = JERK_RESET;
         min_pos = MIN_POS_RESET;
         max_pos = MAX_POS_RESET;
         override_pct = OVERRIDE_RESET;
         cur_pos = 0;
         moving = 0;
         move_dir = 0;
         step_level = 0;
         step_index = 0;
         move_length = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [31:0] value);
         case (index)
            CSR_MAX_SPEED: max_speed = value;
            CSR_MAX_ACCEL: max_accel = value;
            CSR_JERK:      jerk_limit = value;
            CSR_MIN_POS:   min_pos = value[23:0];
            CSR_MAX_POS:   max_pos = value[23:0];
            CSR_OVERRIDE:  override_pct = value[6:0];
            default: ;
         endcase
      endfunction

      // Q16.16 quantity times a Q32.32 interval, giving Q16.16.
      function longint unsigned scale_by_interval(longint unsigned x, longint unsigned t);
         if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
         return x * (t >> 32) + ((x * (t & 64'hFFFF_FFFF)) >> 32);
      endfunction

      function longint unsigned reciprocal(longint unsigned v);
         if (v == 0) v = 1;
         return (64'd1 << 48) / v;
      endfunction

      function logic [31:0] interval_to_ns(longint unsigned t);
         longint unsigned ns;
         ns = (t >> 32) * 64'd1000000000 + (((t & 64'hFFFF_FFFF) * 64'd1000000000) >> 32);
         return (ns > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ns[31:0];
      endfunction

      function void build_intervals(int span);
         longint unsigned sp, ac, jk, v, a, t, d;
         int half, quarter;
         sp = max_speed;
         ac = max_accel;
         jk = jerk_limit;
         v = SPEED_FLOOR;
         a = 0;
         t = 64'd1 << 31;
         half = (span + 1) / 2;
         quarter = span / 4;
         for (int p = 0; p < half && p < 8192; p++) begin
            if (v < sp) begin
               if (p < quarter) begin
                  a += scale_by_interval(jk, t);
                  if (a > ac) a = ac;
               end else begin
                  d = scale_by_interval(jk, t);
                  a = (a > d) ? a - d : 0;
               end
               v += scale_by_interval(a, t);
               if (v > sp) begin
                  v = sp;
                  a = 0;
               end else if (p >= quarter && v < SPEED_FLOOR) begin
                  v = SPEED_FLOOR;
                  a = 0;
               end
               t = reciprocal(v);
            end else begin
               t = reciprocal(sp);
               v = sp;
               a = 0;
            end
            half_intervals[p] = interval_to_ns(t);
         end
      endfunction

      function void note_request(logic op, logic signed [23:0] target, logic fault);
         pulse_result_type r;
         int diff, span, half, idx, factor;
         longint unsigned ns;
         r.interval_ns = 0;
         if (op == OP_MOVE) begin
            diff = int'(target) - int'(cur_pos);
            span = (diff < 0) ? -diff : diff;
            if (!moving && diff != 0 && target >= min_pos && target <= max_pos &&
                span <= MAX_DISTANCE_DEFAULT) begin
               build_intervals(span);
               move_length = span;
               step_index = 0;
               move_dir = diff > 0;
               moving = 1;
               moves_accepted++;
               r.status = STATUS_OK;
            end else begin
               r.status = STATUS_REJECTED;
            end
         end else if (fault) begin
            r.status = STATUS_FAULT;
         end else if (moving && step_index < move_length) begin
            half = (move_length + 1) / 2;
            idx = (step_index < half) ? step_index : move_length - 1 - step_index;
            factor = 100 / ((override_pct == 0) ? 1 : int'(override_pct));
            step_index++;
            step_level = !step_level;
            cur_pos = move_dir ? cur_pos + 24'sd1 : cur_pos - 24'sd1;
            ns = longint'(half_intervals[idx]) * factor;
            r.interval_ns = (ns > 64'hF_FFFF_FFFF) ? 36'hF_FFFF_FFFF : ns[35:0];
            r.status = STATUS_OK;
         end else if (moving) begin
            moving = 0;
            moves_finished++;
            r.status = STATUS_FINISHED;
         end else begin
            r.status = STATUS_IDLE;
         end
         r.position = cur_pos;
         r.direction = move_dir;
         r.pulse_level = step_level;
         r.enable = moving;
         expected_results.push_back(r);
      endfunction

      function void check_result(pulse_result_type got);
         pulse_result_type want;
         checked++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Result with no request outstanding: status %0d",
                                           got.status);
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status || got.interval_ns !== want.interval_ns ||
             got.position !== want.position || got.direction !== want.direction ||
             got.pulse_level !== want.pulse_level || got.enable !== want.enable) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Result %0d expected: st %0d int %0d pos %0d dir %b lvl %b en %b",
                        checked, want.status, want.interval_ns, $signed(want.position),
                        want.direction, want.pulse_level, want.enable);
               $display("Result %0d actual:   st %0d int %0d pos %0d dir %b lvl %b en %b",
                        checked, got.status, got.interval_ns, $signed(got.position),
                        got.direction, got.pulse_level, got.enable);
            end
         end
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   ssp_req_if req();
   ssp_rsp_if rsp();
   ssp_csr_if csr();

   stepper_scurve_pulse_profiler dut (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp), .csr_ch(csr)
   );

   pulse_scoreboard sb = new();
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_cycles = 0;
   int items_sent = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // The receiver counts down a hold-off of its own; otherwise it stalls at random.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp.ready <= ($urandom % 100) >= receiver_stall_pct;
      end
   end

   always @(posedge clock) begin
      pulse_result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.status = rsp.status;
         got.interval_ns = rsp.interval_ns;
         got.position = rsp.position;
         got.direction = rsp.direction;
         got.pulse_level = rsp.pulse_level;
         got.enable = rsp.enable;
         sb.check_result(got);
      end
   end

   task automatic send_request(logic op, logic signed [23:0] target, logic fault);
      while (($urandom % 100) < sender_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.op <= op;
      req.target_position <= target;
      req.fault <= fault;
      do @(posedge clock); while (!req.ready);
      sb.note_request(op, target, fault);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      sb.write_register(index, value);
      @(negedge clock);
      csr.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req.valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // A move of the given signed distance followed by enough ticks to finish it.
   task automatic run_move(int distance, int fault_pct);
      logic signed [23:0] target;
      int ticks;
      target = 24'(sb.cur_pos + distance);
      send_request(OP_MOVE, target, 1'($urandom % 2));
      ticks = (distance < 0 ? -distance : distance) + 1 + $urandom_range(0, 2);
      for (int i = 0; i < ticks; i++) begin
         if (($urandom % 100) < fault_pct) send_request(OP_TICK, 24'($urandom), 1'b1);
         send_request(OP_TICK, 24'($urandom), 1'b0);
         if (sb.moving && ($urandom % 40) == 0) begin
            send_request(OP_MOVE, 24'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic configure_phase(int phase);
      logic [31:0] speed, accel, jerk;
      logic signed [23:0] lo, hi;
      case ($urandom % 4)
         0: speed = 32'd131072;
         1: speed = 32'hFFFF_FFFF;
         2: speed = MAX_SPEED_RESET;
         default: speed = $urandom_range(32'd131072, 32'hFFFF_FFFF);
      endcase
      case ($urandom % 3)
         0: accel = 32'd0;
         1: accel = 32'hFFFF_FFFF;
         default: accel = $urandom;
      endcase
      case ($urandom % 3)
         0: jerk = 32'd0;
         1: jerk = 32'hFFFF_FFFF;
         default: jerk = $urandom >> $urandom_range(0, 20);
      endcase
      if (phase % 2 == 0) begin
         lo = 24'sh800000;
         hi = 24'sh7FFFFF;
      end else begin
         lo = 24'(sb.cur_pos - $urandom_range(0, 3000));
         hi = 24'(sb.cur_pos + $urandom_range(0, 3000));
      end
      write_register(CSR_MAX_SPEED, speed);
      write_register(CSR_MAX_ACCEL, accel);
      write_register(CSR_JERK, jerk);
      write_register(CSR_MIN_POS, {{8{lo[23]}}, lo});
      write_register(CSR_MAX_POS, {{8{hi[23]}}, hi});
      write_register(CSR_OVERRIDE, (phase == 1) ? 32'd1 : (phase == 2) ? 32'd100 :
                     $urandom_range(1, 100));
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 0;
      req.op = 0;
      req.target_position = 0;
      req.fault = 0;
      csr.valid = 0;
      csr.index = 0;
      csr.data = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: idle tick, fault hold, rejections at the limits, fault on a command,
      // a second move rejected while the first one runs, the finishing tick.
      send_request(OP_TICK, 24'sd0, 1'b0);
      send_request(OP_TICK, 24'sd0, 1'b1);
      send_request(OP_MOVE, 24'sd0, 1'b0);
      send_request(OP_MOVE, -24'sd1, 1'b0);
      send_request(OP_MOVE, 24'sd9601, 1'b0);
      send_request(OP_MOVE, 24'sd3, 1'b1);
      send_request(OP_TICK, 24'sd0, 1'b0);
      send_request(OP_TICK, 24'sd0, 1'b1);
      send_request(OP_MOVE, 24'sd1, 1'b0);
      repeat (4) send_request(OP_TICK, 24'sh7FFFFF, 1'b0);
      send_request(OP_TICK, 24'sd0, 1'b0);
      wait_until_drained();
      write_register(CSR_MIN_POS, 32'hFF80_0000);
      write_register(CSR_MAX_POS, 32'h007F_FFFF);
      write_register(CSR_OVERRIDE, 32'd1);
      write_register(CSR_MAX_SPEED, 32'd131072);
      // Extremes of the position range, one pulse beyond the longest move, then a slow move.
      send_request(OP_MOVE, 24'sh7FFFFF, 1'b0);
      send_request(OP_MOVE, 24'sh800000, 1'b0);
      send_request(OP_MOVE, 24'sd16388, 1'b0);
      send_request(OP_MOVE, -24'sd397, 1'b0);
      repeat (402) send_request(OP_TICK, 24'sd0, 1'b0);
      wait_until_drained();
      write_register(CSR_MAX_SPEED, MAX_SPEED_RESET);
      write_register(CSR_OVERRIDE, 32'd100);
      run_move(-300, 0);
      wait_until_drained();

      for (int phase = 0; phase < 4; phase++) begin
         configure_phase(phase);
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
            default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
         endcase
         if (phase == 2) hold_off_cycles = 400;
         for (int n = 0; n < 175; ) begin
            int before_count;
            before_count = items_sent;
            case ($urandom % 10)
               0: send_request(OP_MOVE, 24'($urandom), 1'($urandom));
               1: send_request(OP_TICK, 24'($urandom), 1'($urandom));
               2: run_move($urandom_range(1, 2) * (($urandom % 2) ? 1 : -1), 10);
               default: run_move($urandom_range(1, 40) * (($urandom % 2) ? 1 : -1), 10);
            endcase
            n += items_sent - before_count;
         end
         wait_until_drained();
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (50) @(negedge clock);

      $display("Covered %0d transactions, %0d moves accepted and %0d finished,",
               items_sent, sb.moves_accepted, sb.moves_finished);
      $display("over four register settings and all idling patterns; %0d mismatches.",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("Timed out with %0d results outstanding", sb.outstanding());
      $display("Verification failed");
      $finish;
   end
endmodule
